@@ rtl/core/msm_pkg.sv @@
// Package for the multi-pattern string matcher.
// Holds sizes, command and result codes, and the result record type.
// No dependencies.
package msm_pkg;

    localparam int NODES       = 256;
    localparam int NODE_BITS   = $clog2(NODES);
    localparam int PATTERNS    = 16;
    localparam int PAT_BITS    = $clog2(PATTERNS);
    localparam int OFFSET_BITS = 20;
    localparam int GOTO_BITS   = NODE_BITS + 8;

    localparam logic [1:0] CMD_CLEAR   = 2'd0;
    localparam logic [1:0] CMD_PATTERN = 2'd1;
    localparam logic [1:0] CMD_TEXT    = 2'd2;

    localparam logic [1:0] KIND_MATCH   = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_REJECT  = 2'd2;

    typedef struct packed {
        logic [1:0]             kind;
        logic [15:0]            match_rule;
        logic [OFFSET_BITS-1:0] match_start;
        logic [OFFSET_BITS-1:0] match_end;
        logic [7:0]             match_length;
        logic                   found_any;
    } result_t;

endpackage

@@ rtl/core/msm_if.sv @@
// Channel interfaces of the multi-pattern string matcher.
// Depends on msm_pkg for the offset width.
interface msm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [7:0]  byte_value;
    logic [15:0] rule_number;
    logic        last_byte;

    modport source (output valid, cmd, byte_value, rule_number, last_byte, input ready);
    modport sink (input valid, cmd, byte_value, rule_number, last_byte, output ready);
endinterface

interface msm_out_if
    import msm_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [15:0]            match_rule;
    logic [OFFSET_BITS-1:0] match_start;
    logic [OFFSET_BITS-1:0] match_end;
    logic [7:0]             match_length;
    logic                   found_any;
    logic                   last_result;

    modport source (output valid, kind, match_rule, match_start, match_end,
                    match_length, found_any, last_result, input ready);
    modport sink (input valid, kind, match_rule, match_start, match_end,
                  match_length, found_any, last_result, output ready);
endinterface

@@ rtl/core/multi_pattern_string_matcher.sv @@
// Top level of the multi-pattern string matcher: trie, link builder and scanner.
// Depends on msm_pkg and the channel interfaces in msm_if.sv.
// A pattern byte reads and checks the goto memory and ends the pattern when last; once the pattern
// has failed, its bytes skip the lookup. A text byte follows failure links to a goto hit or the
// root, then checks every stored pattern for each node on the output chain, stalling while the
// result port is full; one byte at a time. A links rebuild before a text byte scans every byte
// value of every node; reset and every clear sweep the goto memory, not ready meanwhile.
module multi_pattern_string_matcher
    import msm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    msm_in_if.sink      req,
    msm_out_if.source   rsp
);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_P_RD, S_P_CHK, S_P_END,
        S_B_START, S_B_CRD, S_B_CWT, S_B_FRD, S_B_FWT, S_B_FFW, S_B_WR, S_B_NEXT,
        S_B_QW, S_B_UF, S_B_UW,
        S_T_RD, S_T_WT, S_T_FW, S_T_POS, S_T_PAT, S_T_NF, S_T_SUM, S_FLUSH
    } state_t;

    state_t                 state_reg;
    logic                   mode_reg;
    logic [GOTO_BITS-1:0]   clr_cnt_reg;
    logic [7:0]             byte_reg;
    logic [15:0]            rule_reg;
    logic                   last_reg;
    logic [NODE_BITS:0]     node_count_reg;
    logic [PAT_BITS:0]      pattern_total_reg;
    logic                   links_valid_reg;
    logic [NODE_BITS-1:0]   load_node_reg;
    logic [8:0]             load_length_reg;
    logic                   load_failed_reg;
    logic [NODE_BITS-1:0]   scan_node_reg;
    logic [OFFSET_BITS-1:0] pos_reg;
    logic                   found_reg;
    logic [NODE_BITS-1:0]   cur_reg;
    logic [NODE_BITS-1:0]   node_reg;
    logic [PAT_BITS:0]      p_reg;
    logic [NODE_BITS-1:0]   u_reg;
    logic [NODE_BITS-1:0]   fu_reg;
    logic [NODE_BITS-1:0]   f_reg;
    logic [NODE_BITS-1:0]   v_reg;
    logic [NODE_BITS-1:0]   w_reg;
    logic [7:0]             c_reg;
    logic [NODE_BITS-1:0]   head_reg;
    logic [NODE_BITS-1:0]   tail_reg;
    result_t                pend_reg;
    logic                   pend_valid_reg;
    result_t                out_reg;
    logic                   out_last_reg;
    logic                   out_valid_reg;

    logic [NODE_BITS-1:0]   goto_mem [2**GOTO_BITS];
    logic [NODE_BITS-1:0]   fail_mem [NODES];
    logic [NODE_BITS-1:0]   queue_mem [NODES];
    logic [NODE_BITS-1:0]   pat_node_reg [PATTERNS];
    logic [15:0]            pat_rule_reg [PATTERNS];
    logic [7:0]             pat_len_reg [PATTERNS];

    logic [GOTO_BITS-1:0]   g_raddr;
    logic [NODE_BITS-1:0]   g_rdata;
    logic                   g_we;
    logic [GOTO_BITS-1:0]   g_waddr;
    logic [NODE_BITS-1:0]   g_wdata;
    logic [NODE_BITS-1:0]   f_raddr;
    logic [NODE_BITS-1:0]   f_rdata;
    logic [NODE_BITS-1:0]   q_rdata;
    logic                   link_we;

    logic                   out_free;
    logic                   out_load;
    logic                   gen_req;
    logic                   gen_ok;
    result_t                gen;
    logic                   reject;
    logic                   pat_hit;
    logic [PAT_BITS-1:0]    p_idx;
    logic [OFFSET_BITS-1:0] pat_len_wide;

    assign out_free     = !out_valid_reg || rsp.ready;
    assign gen_ok       = !pend_valid_reg || out_free;
    assign out_load     = (gen_req && gen_ok && pend_valid_reg)
                          || (state_reg == S_FLUSH && pend_valid_reg && out_free);
    assign reject       = load_failed_reg || (pattern_total_reg >= (PAT_BITS+1)'(PATTERNS))
                          || load_length_reg[8];
    assign p_idx        = p_reg[PAT_BITS-1:0];
    assign pat_hit      = (p_reg < pattern_total_reg) && (pat_node_reg[p_idx] == node_reg);
    assign pat_len_wide = OFFSET_BITS'(pat_len_reg[p_idx]);
    assign link_we      = (state_reg == S_B_WR);

    always_comb
    begin
        gen_req = 1'b0;
        gen     = '0;
        case (state_reg)
            S_P_END:
            begin
                gen_req         = reject;
                gen.kind        = KIND_REJECT;
                gen.match_rule  = rule_reg;
            end
            S_T_PAT:
            begin
                gen_req           = pat_hit && !mode_reg;
                gen.kind          = KIND_MATCH;
                gen.match_rule    = pat_rule_reg[p_idx];
                gen.match_start   = (pos_reg >= pat_len_wide) ? pos_reg - pat_len_wide : '0;
                gen.match_end     = pos_reg;
                gen.match_length  = pat_len_reg[p_idx];
            end
            S_T_SUM:
            begin
                gen_req        = last_reg;
                gen.kind       = KIND_SUMMARY;
                gen.match_end  = pos_reg;
                gen.found_any  = found_reg;
            end
            default:
            begin
                gen_req = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_P_RD:  g_raddr = {load_node_reg, byte_reg};
            S_B_CRD: g_raddr = {u_reg, c_reg};
            S_B_FRD: g_raddr = {f_reg, c_reg};
            S_T_RD:  g_raddr = {cur_reg, byte_reg};
            default: g_raddr = '0;
        endcase
        case (state_reg)
            S_B_FWT: f_raddr = f_reg;
            S_B_UF:  f_raddr = u_reg;
            S_T_WT:  f_raddr = cur_reg;
            S_T_PAT: f_raddr = node_reg;
            default: f_raddr = '0;
        endcase
        g_we    = 1'b0;
        g_waddr = clr_cnt_reg;
        g_wdata = '0;
        if (state_reg == S_CLR)
        begin
            g_we = 1'b1;
        end
        else if (state_reg == S_P_CHK && g_rdata == '0
                 && node_count_reg < (NODE_BITS+1)'(NODES))
        begin
            g_we    = 1'b1;
            g_waddr = {load_node_reg, byte_reg};
            g_wdata = node_count_reg[NODE_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
        begin
            goto_mem[g_waddr] <= g_wdata;
        end
        g_rdata <= goto_mem[g_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            fail_mem[v_reg] <= (w_reg != v_reg) ? w_reg : '0;
        end
        f_rdata <= fail_mem[f_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            queue_mem[tail_reg] <= v_reg;
        end
        q_rdata <= queue_mem[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_P_END && !reject)
        begin
            pat_node_reg[pattern_total_reg[PAT_BITS-1:0]] <= load_node_reg;
            pat_rule_reg[pattern_total_reg[PAT_BITS-1:0]] <= rule_reg;
            pat_len_reg[pattern_total_reg[PAT_BITS-1:0]]  <= load_length_reg[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_CLR;
            mode_reg          <= 1'b0;
            clr_cnt_reg       <= '0;
            byte_reg          <= '0;
            rule_reg          <= '0;
            last_reg          <= 1'b0;
            node_count_reg    <= (NODE_BITS+1)'(1);
            pattern_total_reg <= '0;
            links_valid_reg   <= 1'b0;
            load_node_reg     <= '0;
            load_length_reg   <= '0;
            load_failed_reg   <= 1'b0;
            scan_node_reg     <= '0;
            pos_reg           <= '0;
            found_reg         <= 1'b0;
            cur_reg           <= '0;
            node_reg          <= '0;
            p_reg             <= '0;
            u_reg             <= '0;
            fu_reg            <= '0;
            f_reg             <= '0;
            v_reg             <= '0;
            w_reg             <= '0;
            c_reg             <= '0;
            head_reg          <= '0;
            tail_reg          <= '0;
            pend_reg          <= '0;
            pend_valid_reg    <= 1'b0;
            out_reg           <= '0;
            out_last_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                mode_reg <= cfg_write_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (gen_req && gen_ok)
            begin
                if (pend_valid_reg)
                begin
                    out_reg       <= pend_reg;
                    out_last_reg  <= 1'b0;
                end
                pend_reg       <= gen;
                pend_valid_reg <= 1'b1;
            end
            case (state_reg)
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        byte_reg <= req.byte_value;
                        rule_reg <= req.rule_number;
                        last_reg <= req.last_byte;
                        cur_reg  <= scan_node_reg;
                        case (req.cmd)
                            CMD_CLEAR:
                            begin
                                node_count_reg    <= (NODE_BITS+1)'(1);
                                pattern_total_reg <= '0;
                                links_valid_reg   <= 1'b0;
                                load_node_reg     <= '0;
                                load_length_reg   <= '0;
                                load_failed_reg   <= 1'b0;
                                scan_node_reg     <= '0;
                                pos_reg           <= '0;
                                found_reg         <= 1'b0;
                                clr_cnt_reg       <= '0;
                                state_reg         <= S_CLR;
                            end
                            CMD_PATTERN:
                            begin
                                links_valid_reg <= 1'b0;
                                if (!load_length_reg[8])
                                begin
                                    load_length_reg <= load_length_reg + 1'b1;
                                end
                                if (!load_failed_reg)
                                begin
                                    state_reg <= S_P_RD;
                                end
                                else if (req.last_byte)
                                begin
                                    state_reg <= S_P_END;
                                end
                            end
                            CMD_TEXT:
                            begin
                                state_reg <= links_valid_reg ? S_T_RD : S_B_START;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_P_RD:
                begin
                    state_reg <= S_P_CHK;
                end
                S_P_CHK:
                begin
                    if (g_rdata != '0)
                    begin
                        load_node_reg <= g_rdata;
                    end
                    else if (node_count_reg >= (NODE_BITS+1)'(NODES))
                    begin
                        load_failed_reg <= 1'b1;
                    end
                    else
                    begin
                        load_node_reg  <= node_count_reg[NODE_BITS-1:0];
                        node_count_reg <= node_count_reg + 1'b1;
                    end
                    state_reg <= last_reg ? S_P_END : S_IDLE;
                end
                S_P_END:
                begin
                    if (!reject || gen_ok)
                    begin
                        if (!reject)
                        begin
                            pattern_total_reg <= pattern_total_reg + 1'b1;
                        end
                        load_node_reg   <= '0;
                        load_length_reg <= '0;
                        load_failed_reg <= 1'b0;
                        state_reg       <= S_FLUSH;
                    end
                end
                S_B_START:
                begin
                    u_reg     <= '0;
                    fu_reg    <= '0;
                    c_reg     <= '0;
                    head_reg  <= '0;
                    tail_reg  <= '0;
                    state_reg <= S_B_CRD;
                end
                S_B_CRD:
                begin
                    state_reg <= S_B_CWT;
                end
                S_B_CWT:
                begin
                    v_reg <= g_rdata;
                    f_reg <= fu_reg;
                    w_reg <= '0;
                    if (g_rdata == '0)
                    begin
                        state_reg <= S_B_NEXT;
                    end
                    else if (u_reg == '0)
                    begin
                        state_reg <= S_B_WR;
                    end
                    else
                    begin
                        state_reg <= S_B_FRD;
                    end
                end
                S_B_FRD:
                begin
                    state_reg <= S_B_FWT;
                end
                S_B_FWT:
                begin
                    if (g_rdata != '0 || f_reg == '0)
                    begin
                        w_reg     <= g_rdata;
                        state_reg <= S_B_WR;
                    end
                    else
                    begin
                        state_reg <= S_B_FFW;
                    end
                end
                S_B_FFW:
                begin
                    f_reg     <= f_rdata;
                    state_reg <= S_B_FRD;
                end
                S_B_WR:
                begin
                    tail_reg  <= tail_reg + 1'b1;
                    state_reg <= S_B_NEXT;
                end
                S_B_NEXT:
                begin
                    if (c_reg != '1)
                    begin
                        c_reg     <= c_reg + 1'b1;
                        state_reg <= S_B_CRD;
                    end
                    else if (head_reg != tail_reg)
                    begin
                        head_reg  <= head_reg + 1'b1;
                        state_reg <= S_B_QW;
                    end
                    else
                    begin
                        links_valid_reg <= 1'b1;
                        state_reg       <= S_T_RD;
                    end
                end
                S_B_QW:
                begin
                    u_reg     <= q_rdata;
                    state_reg <= S_B_UF;
                end
                S_B_UF:
                begin
                    state_reg <= S_B_UW;
                end
                S_B_UW:
                begin
                    fu_reg    <= f_rdata;
                    c_reg     <= '0;
                    state_reg <= S_B_CRD;
                end
                S_T_RD:
                begin
                    state_reg <= S_T_WT;
                end
                S_T_WT:
                begin
                    if (g_rdata != '0)
                    begin
                        cur_reg   <= g_rdata;
                        state_reg <= S_T_POS;
                    end
                    else if (cur_reg == '0)
                    begin
                        state_reg <= S_T_POS;
                    end
                    else
                    begin
                        state_reg <= S_T_FW;
                    end
                end
                S_T_FW:
                begin
                    cur_reg   <= f_rdata;
                    state_reg <= S_T_RD;
                end
                S_T_POS:
                begin
                    scan_node_reg <= cur_reg;
                    if (pos_reg != '1)
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                    node_reg  <= cur_reg;
                    p_reg     <= '0;
                    state_reg <= (cur_reg == '0) ? S_T_SUM : S_T_PAT;
                end
                S_T_PAT:
                begin
                    if (p_reg < pattern_total_reg)
                    begin
                        if (pat_hit)
                        begin
                            found_reg <= 1'b1;
                        end
                        if (!gen_req || gen_ok)
                        begin
                            p_reg <= p_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg <= S_T_NF;
                    end
                end
                S_T_NF:
                begin
                    node_reg  <= f_rdata;
                    p_reg     <= '0;
                    state_reg <= (f_rdata == '0) ? S_T_SUM : S_T_PAT;
                end
                S_T_SUM:
                begin
                    if (!last_reg)
                    begin
                        state_reg <= S_FLUSH;
                    end
                    else if (gen_ok)
                    begin
                        scan_node_reg <= '0;
                        pos_reg       <= '0;
                        found_reg     <= 1'b0;
                        state_reg     <= S_FLUSH;
                    end
                end
                S_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_reg        <= pend_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.kind         = out_reg.kind;
    assign rsp.match_rule   = out_reg.match_rule;
    assign rsp.match_start  = out_reg.match_start;
    assign rsp.match_end    = out_reg.match_end;
    assign rsp.match_length = out_reg.match_length;
    assign rsp.found_any    = out_reg.found_any;
    assign rsp.last_result  = out_last_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !pend_valid_reg)
        else $error("pending result held while ready for a new transaction");

    a_node_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        node_count_reg >= (NODE_BITS+1)'(1) && node_count_reg <= (NODE_BITS+1)'(NODES))
        else $error("node count out of range");

    a_pattern_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        pattern_total_reg <= (PAT_BITS+1)'(PATTERNS))
        else $error("pattern total beyond store size");

    a_scan_needs_links: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_T_RD) |-> links_valid_reg)
        else $error("text scan started without failure links");
`endif

endmodule
